// ===== hdl/amtrs_pkg.sv =====
// Shared types, constants and arithmetic helpers of the TRS decomposition core.
package amtrs_pkg;

   localparam int unsigned RootWidth = 32;
   localparam int unsigned RadWidth  = 64;
   localparam int unsigned DivQWidth = 34;
   localparam int unsigned DivDWidth = 33;
   localparam int unsigned DivNWidth = 33;
   localparam logic signed [33:0] OneQ30 = 34'sd1073741824;

   // Shepherd branch selector
   typedef enum logic [1:0] {
      BR_W = 2'd0,
      BR_X = 2'd1,
      BR_Y = 2'd2,
      BR_Z = 2'd3
   } branch_type;

   // saturate a signed 35-bit value to signed 32 bits
   function automatic logic [31:0] sat_s32(input logic signed [34:0] v);
      logic [31:0] r;
      if (v > 35'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -35'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/amtrs_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module amtrs_sqrt #(
   parameter int unsigned Width = amtrs_pkg::RadWidth,
   parameter int unsigned Tag   = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [Width-1:0]      in_rad,
   input  logic [Tag-1:0]        in_tag,
   output logic                  out_valid,
   output logic [Width/2-1:0]    out_root,
   output logic [Tag-1:0]        out_tag
);
   localparam int unsigned Steps = Width / 2;

   logic [Steps:0]            valid_ff;
   logic [Width-1:0]          rem_ff  [Steps+1];
   logic [Width-1:0]          rad_ff  [Steps+1];
   logic [Steps-1:0]          root_ff [Steps+1];
   logic [Tag-1:0]            tag_ff  [Steps+1];

   always_comb begin
      rem_ff[0]  = '0;
      rad_ff[0]  = in_rad;
      root_ff[0] = '0;
      tag_ff[0]  = in_tag;
      valid_ff[0] = in_valid;
   end

   // one restoring step per stage: bring down two radicand bits
   for (genvar s = 0; s < Steps; s++) begin : g_step
      logic [Width+1:0] trial_in;
      logic [Width+1:0] cand_in;
      always_comb begin
         trial_in = {rem_ff[s], rad_ff[s][Width-1 -: 2]};
         cand_in  = {{(Width-Steps){1'b0}}, root_ff[s], 2'b01};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[s+1] <= valid_ff[s];
         end
         if (advance) begin
            if (trial_in >= cand_in) begin
               rem_ff[s+1]  <= Width'(trial_in - cand_in);
               root_ff[s+1] <= {root_ff[s][Steps-2:0], 1'b1};
            end else begin
               rem_ff[s+1]  <= trial_in[Width-1:0];
               root_ff[s+1] <= {root_ff[s][Steps-2:0], 1'b0};
            end
            rad_ff[s+1] <= {rad_ff[s][Width-3:0], 2'b00};
            tag_ff[s+1] <= tag_ff[s];
         end
      end
   end

   assign out_valid = valid_ff[Steps];
   assign out_root  = root_ff[Steps];
   assign out_tag   = tag_ff[Steps];
endmodule

// ===== hdl/amtrs_div.sv =====
// Pipelined rounded divide: round(num * 2^30 / den), ties away from zero.
module amtrs_div (
   input  logic                                clock,
   input  logic                                advance,
   input  logic signed [amtrs_pkg::DivNWidth:0] in_num,
   input  logic [amtrs_pkg::DivDWidth-1:0]      in_den,
   output logic signed [34:0]                   out_quot
);
   localparam int unsigned NW    = amtrs_pkg::DivNWidth;
   localparam int unsigned DW    = amtrs_pkg::DivDWidth;
   localparam int unsigned QW    = amtrs_pkg::DivQWidth;
   localparam int unsigned DvW   = NW + 30 + 1;
   localparam int unsigned Steps = QW;

   // dividend = mag*2^30 + den/2; quotient kept to QW bits (saturation caught later)
   logic [DvW-1:0]  dvd_ff [Steps+1];
   logic [DW-1:0]   den_ff [Steps+1];
   logic [DW:0]     rem_ff [Steps+1];
   logic [QW-1:0]   q_ff   [Steps+1];
   logic [Steps:0]  neg_ff;
   logic [Steps:0]  ovf_ff;
   logic [NW-1:0]   mag_in;

   // dividend bits above the quotient window seed the partial remainder;
   // if they already reach the divisor the quotient does not fit
   always_comb begin
      mag_in = in_num[NW] ? NW'(-in_num) : in_num[NW-1:0];
      dvd_ff[0] = {1'b0, mag_in, 30'd0} + DvW'(in_den >> 1);
      den_ff[0] = in_den;
      rem_ff[0] = (DW+1)'(dvd_ff[0][DvW-1:QW]);
      q_ff[0]   = '0;
      neg_ff[0] = in_num[NW];
      ovf_ff[0] = (DW+1)'(dvd_ff[0][DvW-1:QW]) >= {1'b0, in_den};
   end

   // one restoring step per stage over the quotient window
   for (genvar s = 0; s < Steps; s++) begin : g_step
      logic [DW+1:0] trial_in;
      always_comb begin
         trial_in = {rem_ff[s], dvd_ff[s][QW-1-s]};
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            dvd_ff[s+1] <= dvd_ff[s];
            den_ff[s+1] <= den_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            ovf_ff[s+1] <= ovf_ff[s];
            if (trial_in >= {1'b0, den_ff[s]}) begin
               rem_ff[s+1] <= (DW+1)'(trial_in - {1'b0, den_ff[s]});
               q_ff[s+1]   <= {q_ff[s][QW-2:0], 1'b1};
            end else begin
               rem_ff[s+1] <= trial_in[DW:0];
               q_ff[s+1]   <= {q_ff[s][QW-2:0], 1'b0};
            end
         end
      end
   end

   logic [34:0] mag_out;
   always_comb begin
      mag_out  = ovf_ff[Steps] ? 35'h0_FFFF_FFFF : {1'b0, q_ff[Steps]};
      out_quot = neg_ff[Steps] ? -$signed(mag_out) : $signed(mag_out);
   end
endmodule

// ===== hdl/affine_matrix_trs_decompose_core.sv =====
// Top level of the affine matrix TRS decomposition core.
// One matrix is accepted per cycle while the pipeline advances, and one result
// beat leaves per matrix, in order. The stages are: two for the squares and their
// sums, a 32-stage square root for the column lengths, a 34-stage divide for
// normalization, one stage for branch selection, a 32-stage square root for
// the Shepherd radicand, a 34-stage divide for the other quaternion components
// and the output register; the roots and divides take one stage per result
// bit. The whole pipeline advances while the output register is empty or
// being taken, so a stall on the result side holds every stage without loss.
module affine_matrix_trs_decompose_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // col0_x,col0_y,col0_z,col1_x,col1_y,col1_z,col2_x,col2_y,col2_z,col3_x,col3_y,col3_z
   input  logic [383:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pos_x,pos_y,pos_z,scale_x,scale_y,scale_z,quat_w,quat_x,quat_y,quat_z
   output logic [319:0] rsp_tdata
);
   localparam int unsigned SqW  = amtrs_pkg::RadWidth;
   localparam int unsigned SqS  = SqW / 2;
   localparam int unsigned DvS  = amtrs_pkg::DivQWidth;

   logic advance;
   logic out_valid_ff;
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   // ---- stage A: squares of entries; stage B: sum per column
   logic signed [31:0] ent [12];
   for (genvar i = 0; i < 12; i++) begin : g_ent
      assign ent[i] = req_tdata[32*i +: 32];
   end

   logic [63:0] sq_ff [9];
   logic        a_valid_ff;
   logic [383:0] a_data_ff;
   for (genvar i = 0; i < 9; i++) begin : g_sq
      logic [31:0] m_in;
      assign m_in = ent[i][31] ? 32'(-ent[i]) : ent[i];
      always_ff @(posedge clock) begin
         if (advance) sq_ff[i] <= m_in * m_in;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) a_valid_ff <= 1'b0;
      else if (advance) a_valid_ff <= req_tvalid;
      if (advance) a_data_ff <= req_tdata;
   end

   logic [63:0] sum_ff [3];
   logic        b_valid_ff;
   logic [383:0] b_data_ff;
   always_ff @(posedge clock) begin
      if (reset) b_valid_ff <= 1'b0;
      else if (advance) b_valid_ff <= a_valid_ff;
      if (advance) begin
         b_data_ff <= a_data_ff;
         for (int c = 0; c < 3; c++) sum_ff[c] <= sq_ff[3*c] + sq_ff[3*c+1] + sq_ff[3*c+2];
      end
   end

   // ---- column length square roots; matrix rides along as tag
   logic [SqS-1:0] len [3];
   logic           c_valid;
   logic [383:0]   c_data;
   for (genvar c = 0; c < 3; c++) begin : g_len
      if (c == 0) begin : g_tagged
         amtrs_sqrt #(.Width(SqW), .Tag(384)) u_sqrt (
            .clock, .reset, .advance, .in_valid(b_valid_ff), .in_rad(sum_ff[c]),
            .in_tag(b_data_ff), .out_valid(c_valid), .out_root(len[c]), .out_tag(c_data));
      end else begin : g_plain
         logic       unused_v;
         logic [0:0] unused_t;
         amtrs_sqrt #(.Width(SqW), .Tag(1)) u_sqrt (
            .clock, .reset, .advance, .in_valid(b_valid_ff), .in_rad(sum_ff[c]),
            .in_tag(1'b0), .out_valid(unused_v), .out_root(len[c]), .out_tag(unused_t));
      end
   end

   // ---- normalize: nine divides, zero columns replaced after
   logic signed [34:0] nq [9];
   for (genvar i = 0; i < 9; i++) begin : g_norm
      logic signed [32:0] num_in;
      assign num_in = 33'(signed'(c_data[32*i +: 32]));
      amtrs_div u_div (.clock, .advance, .in_num({num_in[32], num_in}),
         .in_den({1'b0, len[i/3]}), .out_quot(nq[i]));
   end
   // delay line for valid, translation and lengths across the divider
   logic [DvS:0]  d_valid_ff;
   logic [191:0]  d_side_ff [DvS+1];
   always_comb begin
      d_valid_ff[0] = c_valid;
      d_side_ff[0]  = {len[2], len[1], len[0], c_data[383:288]};
   end
   for (genvar s = 0; s < DvS; s++) begin : g_dl
      always_ff @(posedge clock) begin
         if (reset) d_valid_ff[s+1] <= 1'b0;
         else if (advance) d_valid_ff[s+1] <= d_valid_ff[s];
         if (advance) d_side_ff[s+1] <= d_side_ff[s];
      end
   end

   // ---- stage E: normalized matrix r[col][row], branch choice, radicand
   logic signed [33:0] r_in [9];
   logic signed [33:0] d0, d1, d2, tr;
   logic signed [33:0] n0_in, n1_in, n2_in, t_in;
   amtrs_pkg::branch_type br_in;
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         if (d_side_ff[DvS][96 + 32*(i/3) +: 32] == '0)
            r_in[i] = ((i % 3) == (i / 3)) ? amtrs_pkg::OneQ30 : 34'sd0;
         else
            r_in[i] = nq[i][33:0];
      end
      d0 = r_in[0]; d1 = r_in[4]; d2 = r_in[8];
      tr = d0 + d1 + d2;
      if (tr > 0) begin
         br_in = amtrs_pkg::BR_W;
         n0_in = r_in[5] - r_in[7]; n1_in = r_in[6] - r_in[2]; n2_in = r_in[1] - r_in[3];
         t_in  = tr + amtrs_pkg::OneQ30;
      end else if (d0 > d1 && d0 > d2) begin
         br_in = amtrs_pkg::BR_X;
         n0_in = r_in[5] - r_in[7]; n1_in = r_in[3] + r_in[1]; n2_in = r_in[6] + r_in[2];
         t_in  = amtrs_pkg::OneQ30 + d0 - d1 - d2;
      end else if (d1 > d2) begin
         br_in = amtrs_pkg::BR_Y;
         n0_in = r_in[6] - r_in[2]; n1_in = r_in[3] + r_in[1]; n2_in = r_in[7] + r_in[5];
         t_in  = amtrs_pkg::OneQ30 + d1 - d0 - d2;
      end else begin
         br_in = amtrs_pkg::BR_Z;
         n0_in = r_in[1] - r_in[3]; n1_in = r_in[6] + r_in[2]; n2_in = r_in[7] + r_in[5];
         t_in  = amtrs_pkg::OneQ30 + d2 - d0 - d1;
      end
   end

   // radicand t reaches 4.0 (bit 32) for a pure rotation; negative t reads as zero
   logic               e_valid_ff;
   logic [63:0]        e_rad_ff;
   logic [292:0]       e_side_ff;
   always_ff @(posedge clock) begin
      if (reset) e_valid_ff <= 1'b0;
      else if (advance) e_valid_ff <= d_valid_ff[DvS];
      if (advance) begin
         e_rad_ff  <= t_in[33] ? 64'd0 : {1'b0, t_in[32:0], 30'd0};
         e_side_ff <= {br_in, n2_in[32:0], n1_in[32:0], n0_in[32:0], d_side_ff[DvS]};
      end
   end

   // ---- Shepherd root
   logic [SqS-1:0] root;
   logic           f_valid;
   logic [292:0]   f_side;
   amtrs_sqrt #(.Width(SqW), .Tag(293)) u_qsqrt (
      .clock, .reset, .advance, .in_valid(e_valid_ff), .in_rad(e_rad_ff),
      .in_tag(e_side_ff), .out_valid(f_valid), .out_root(root), .out_tag(f_side));

   // ---- three divides by 2*root
   logic signed [34:0] qd [3];
   for (genvar k = 0; k < 3; k++) begin : g_qdiv
      logic signed [32:0] n_in;
      assign n_in = f_side[192 + 33*k +: 33];
      amtrs_div u_div (.clock, .advance, .in_num({n_in[32], n_in}),
         .in_den({root, 1'b0}), .out_quot(qd[k]));
   end
   logic [DvS:0]  g_valid_ff;
   logic [225:0]  g_side_ff [DvS+1];
   always_comb begin
      g_valid_ff[0] = f_valid;
      g_side_ff[0]  = {f_side[292:291], root[31:0], f_side[191:0]};
   end
   for (genvar s = 0; s < DvS; s++) begin : g_gl
      always_ff @(posedge clock) begin
         if (reset) g_valid_ff[s+1] <= 1'b0;
         else if (advance) g_valid_ff[s+1] <= g_valid_ff[s];
         if (advance) g_side_ff[s+1] <= g_side_ff[s];
      end
   end

   // ---- assemble quaternion into output register
   logic [31:0] q_out [4];
   logic [31:0] rt;
   logic [1:0]  bsel;
   always_comb begin
      rt   = g_side_ff[DvS][223:192];
      bsel = g_side_ff[DvS][225:224];
      for (int i = 0; i < 4; i++) q_out[i] = '0;
      case (amtrs_pkg::branch_type'(bsel))
         amtrs_pkg::BR_W: begin
            q_out[0] = 32'((33'(rt) + 33'd1) >> 1);
            q_out[1] = amtrs_pkg::sat_s32(qd[0]); q_out[2] = amtrs_pkg::sat_s32(qd[1]);
            q_out[3] = amtrs_pkg::sat_s32(qd[2]);
         end
         amtrs_pkg::BR_X: begin
            q_out[1] = 32'((33'(rt) + 33'd1) >> 1);
            q_out[0] = amtrs_pkg::sat_s32(qd[0]); q_out[2] = amtrs_pkg::sat_s32(qd[1]);
            q_out[3] = amtrs_pkg::sat_s32(qd[2]);
         end
         amtrs_pkg::BR_Y: begin
            q_out[2] = 32'((33'(rt) + 33'd1) >> 1);
            q_out[0] = amtrs_pkg::sat_s32(qd[0]); q_out[1] = amtrs_pkg::sat_s32(qd[1]);
            q_out[3] = amtrs_pkg::sat_s32(qd[2]);
         end
         default: begin
            q_out[3] = 32'((33'(rt) + 33'd1) >> 1);
            q_out[0] = amtrs_pkg::sat_s32(qd[0]); q_out[1] = amtrs_pkg::sat_s32(qd[1]);
            q_out[2] = amtrs_pkg::sat_s32(qd[2]);
         end
      endcase
      if (rt == '0) begin
         for (int i = 0; i < 4; i++) q_out[i] = '0;
      end
   end

   logic [319:0] out_data_ff;
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (advance) out_valid_ff <= g_valid_ff[DvS];
      if (advance) out_data_ff <= {q_out[3], q_out[2], q_out[1], q_out[0],
                                   g_side_ff[DvS][191:0]};
   end
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
endmodule
